/* design/i128alu_pkg.sv */
package i128alu_pkg;

    typedef enum logic [2:0] {
        ACT_SEXT = 3'd0,
        ACT_NEG  = 3'd1,
        ACT_ADD  = 3'd2,
        ACT_SUB  = 3'd3,
        ACT_MUL  = 3'd4,
        ACT_SHL  = 3'd5,
        ACT_SHR  = 3'd6,
        ACT_SAR  = 3'd7
    } action_t;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned VALUE_W = 128;
    localparam int unsigned SHAMT_W = 7;
    localparam int unsigned FINE_W  = 4;

    typedef struct packed {
        action_t             action;
        logic [WORD_W-1:0]   a_lo;
        logic [WORD_W-1:0]   a_hi;
        logic [WORD_W-1:0]   b_lo;
        logic [WORD_W-1:0]   b_hi;
        logic [SHAMT_W-1:0]  shift_amount;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] res_lo;
        logic [WORD_W-1:0] res_hi;
    } rsp_t;

endpackage

/* design/int128_alu_unit.sv */
// 128-bit two's complement ALU, three register stages.
// req channel: req_valid / req_stall / req carry one operation (action, operand a and b
// as 64-bit halves, shift amount). rsp channel: rsp_valid / rsp_stall / rsp carry the
// 128-bit result as res_lo / res_hi. A transfer happens on a rising edge with valid high
// and stall low. Every operation yields exactly one result, in order.
// The request transfer loads s1, then s2 and then the output register, each as soon as
// the stage after it can move on; the result is presented from the output register.
// Throughput: one operation per cycle while rsp_stall stays low; the depth is set by
// the 32x32 partial products of the multiply (stage 1), their partial sums (stage 2)
// and the final 128-bit sum (stage 3). Adds split their carry chain over stages 1 and
// 2, shifts do 16-bit steps in stage 1 and the rest in stage 2.
// Reset clears all valid bits; the pipe is empty and req_stall is low afterwards.
// When rsp_stall is high the output holds its result; earlier stages keep filling
// until every stage is occupied, and only then is req_stall raised. No operation is
// dropped or repeated under any stall pattern.
module int128_alu_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  i128alu_pkg::req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output i128alu_pkg::rsp_t rsp
);
    import i128alu_pkg::*;

    // stage 1 registers
    logic                s1_valid_reg;
    action_t             s1_action_reg;
    logic [VALUE_W-1:0]  s1_val_reg;
    logic [FINE_W-1:0]   s1_fine_reg;
    logic [WORD_W-1:0]   s1_sum_lo_reg;
    logic                s1_carry_reg;
    logic [WORD_W-1:0]   s1_x_hi_reg;
    logic [WORD_W-1:0]   s1_y_hi_reg;
    logic [WORD_W-1:0]   s1_p0_reg, s1_p1_reg, s1_p2_reg, s1_p3_reg;
    logic [WORD_W-1:0]   s1_q0_reg, s1_r0_reg;
    logic [HALF_W-1:0]   s1_q1_reg, s1_q2_reg, s1_r1_reg, s1_r2_reg;

    // stage 2 registers
    logic                s2_valid_reg;
    action_t             s2_action_reg;
    logic [VALUE_W-1:0]  s2_val_reg;
    logic [WORD_W-1:0]   s2_p0_reg, s2_p3_reg;
    logic [WORD_W:0]     s2_mid_reg;
    logic [WORD_W-1:0]   s2_cross_reg;

    // output register
    logic                s3_valid_reg;
    rsp_t                s3_data_reg;

    logic s1_en, s2_en, s3_en;

    assign s3_en     = !s3_valid_reg || !rsp_stall;
    assign s2_en     = !s2_valid_reg || s3_en;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign req_stall = !s1_en;
    assign rsp_valid = s3_valid_reg;
    assign rsp       = s3_data_reg;

    // ---------------- stage 1: partial products, low add, coarse shift
    logic [VALUE_W-1:0]  a_full;
    logic [SHAMT_W-1:0]  coarse_amt;
    logic [VALUE_W-1:0]  val_next;
    logic [VALUE_W-1:0]  x_full, y_full;
    logic                cin;
    logic [WORD_W:0]     lo_sum;
    logic [WORD_W-1:0]   p0, p1, p2, p3, q0, r0;
    logic [HALF_W-1:0]   q1, q2, r1, r2;

    assign a_full     = {req.a_hi, req.a_lo};
    assign coarse_amt = {req.shift_amount[SHAMT_W-1:FINE_W], {FINE_W{1'b0}}};

    always_comb
    begin
        unique case (req.action)
            ACT_SEXT: val_next = {{WORD_W{req.a_lo[WORD_W-1]}}, req.a_lo};
            ACT_SHL:  val_next = a_full << coarse_amt;
            ACT_SHR:  val_next = a_full >> coarse_amt;
            ACT_SAR:  val_next = VALUE_W'($signed(a_full) >>> coarse_amt);
            default:  val_next = '0;
        endcase
    end

    always_comb
    begin
        unique case (req.action)
            ACT_NEG:
            begin
                x_full = ~a_full;
                y_full = '0;
                cin    = 1'b1;
            end
            ACT_ADD:
            begin
                x_full = a_full;
                y_full = {req.b_hi, req.b_lo};
                cin    = 1'b0;
            end
            ACT_SUB:
            begin
                x_full = a_full;
                y_full = ~{req.b_hi, req.b_lo};
                cin    = 1'b1;
            end
            default:
            begin
                x_full = '0;
                y_full = '0;
                cin    = 1'b0;
            end
        endcase
    end

    assign lo_sum = {1'b0, x_full[WORD_W-1:0]} + {1'b0, y_full[WORD_W-1:0]}
                  + {{WORD_W{1'b0}}, cin};

    // a_lo * b_lo in full, a_lo * b_hi and a_hi * b_lo modulo 2^64
    assign p0 = req.a_lo[HALF_W-1:0]      * req.b_lo[HALF_W-1:0];
    assign p1 = req.a_lo[HALF_W-1:0]      * req.b_lo[WORD_W-1:HALF_W];
    assign p2 = req.a_lo[WORD_W-1:HALF_W] * req.b_lo[HALF_W-1:0];
    assign p3 = req.a_lo[WORD_W-1:HALF_W] * req.b_lo[WORD_W-1:HALF_W];
    assign q0 = req.a_lo[HALF_W-1:0]      * req.b_hi[HALF_W-1:0];
    assign q1 = req.a_lo[HALF_W-1:0]      * req.b_hi[WORD_W-1:HALF_W];
    assign q2 = req.a_lo[WORD_W-1:HALF_W] * req.b_hi[HALF_W-1:0];
    assign r0 = req.a_hi[HALF_W-1:0]      * req.b_lo[HALF_W-1:0];
    assign r1 = req.a_hi[HALF_W-1:0]      * req.b_lo[WORD_W-1:HALF_W];
    assign r2 = req.a_hi[WORD_W-1:HALF_W] * req.b_lo[HALF_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && req_valid)
        begin
            s1_action_reg <= req.action;
            s1_val_reg    <= val_next;
            s1_fine_reg   <= req.shift_amount[FINE_W-1:0];
            s1_sum_lo_reg <= lo_sum[WORD_W-1:0];
            s1_carry_reg  <= lo_sum[WORD_W];
            s1_x_hi_reg   <= x_full[VALUE_W-1:WORD_W];
            s1_y_hi_reg   <= y_full[VALUE_W-1:WORD_W];
            s1_p0_reg     <= p0;
            s1_p1_reg     <= p1;
            s1_p2_reg     <= p2;
            s1_p3_reg     <= p3;
            s1_q0_reg     <= q0;
            s1_q1_reg     <= q1;
            s1_q2_reg     <= q2;
            s1_r0_reg     <= r0;
            s1_r1_reg     <= r1;
            s1_r2_reg     <= r2;
        end
    end

    // ---------------- stage 2: high add, fine shift, partial sums
    logic [VALUE_W-1:0] s2_val_next;
    logic [WORD_W-1:0]  sum_hi;
    logic [HALF_W-1:0]  cross_top;
    logic [WORD_W:0]    mid_next;
    logic [WORD_W-1:0]  cross_next;

    assign sum_hi     = s1_x_hi_reg + s1_y_hi_reg + {{(WORD_W-1){1'b0}}, s1_carry_reg};
    assign cross_top  = s1_q1_reg + s1_q2_reg + s1_r1_reg + s1_r2_reg;
    assign mid_next   = {1'b0, s1_p1_reg} + {1'b0, s1_p2_reg};
    assign cross_next = s1_q0_reg + s1_r0_reg + {cross_top, {HALF_W{1'b0}}};

    always_comb
    begin
        unique case (s1_action_reg)
            ACT_SEXT: s2_val_next = s1_val_reg;
            ACT_NEG,
            ACT_ADD,
            ACT_SUB:  s2_val_next = {sum_hi, s1_sum_lo_reg};
            ACT_SHL:  s2_val_next = s1_val_reg << s1_fine_reg;
            ACT_SHR:  s2_val_next = s1_val_reg >> s1_fine_reg;
            ACT_SAR:  s2_val_next = VALUE_W'($signed(s1_val_reg) >>> s1_fine_reg);
            default:  s2_val_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            s2_action_reg <= s1_action_reg;
            s2_val_reg    <= s2_val_next;
            s2_p0_reg     <= s1_p0_reg;
            s2_p3_reg     <= s1_p3_reg;
            s2_mid_reg    <= mid_next;
            s2_cross_reg  <= cross_next;
        end
    end

    // ---------------- stage 3: final product sum, output register
    logic [VALUE_W-1:0] prod;
    logic [VALUE_W-1:0] s3_val_next;

    assign prod = {s2_p3_reg, s2_p0_reg}
                + {{(VALUE_W-WORD_W-1-HALF_W){1'b0}}, s2_mid_reg, {HALF_W{1'b0}}}
                + {s2_cross_reg, {WORD_W{1'b0}}};

    assign s3_val_next = (s2_action_reg == ACT_MUL) ? prod : s2_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en && s2_valid_reg)
        begin
            s3_data_reg.res_lo <= s3_val_next[WORD_W-1:0];
            s3_data_reg.res_hi <= s3_val_next[VALUE_W-1:WORD_W];
        end
    end

    // ---------------- assertions
    // a transfer always lands in stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> s1_valid_reg)
        else $error("accepted request not captured in stage 1");

    // back pressure only when every stage holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && rsp_stall))
        else $error("request stalled while the pipe has room");

    // a blocked stage 2 item keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_en) |=> (s2_valid_reg && $stable(s2_val_reg)))
        else $error("stage 2 item lost or changed under stall");

    // a stage 1 item moves on whenever stage 2 frees up
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_en) |=> s2_valid_reg)
        else $error("stage 1 item dropped");

endmodule

/* sim/tb_int128_alu_unit.sv */
`timescale 1ns / 1ps

module tb_int128_alu_unit;
    import i128alu_pkg::*;

    localparam int unsigned RANDOM_OPS   = 1700;
    localparam int unsigned PHASES       = 4;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned SHOWN_ERRORS = 10;

    typedef struct packed {
        req_t op;
        rsp_t res;
    } pending_op_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;

    int unsigned req_idle_pct;
    int unsigned rsp_stall_pct;
    int unsigned quiet_cycles;

    int unsigned idle_by_phase [PHASES] = '{0, 58, 0, 11};
    int unsigned stall_by_phase[PHASES] = '{0, 0, 58, 11};

    int128_alu_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 128-bit result of one operation, wrapping modulo 2^128
    function automatic rsp_t alu_result(req_t op);
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        logic [VALUE_W-1:0] v;
        rsp_t               r;
        a = {op.a_hi, op.a_lo};
        b = {op.b_hi, op.b_lo};
        case (op.action)
            ACT_SEXT: v = {{WORD_W{op.a_lo[WORD_W-1]}}, op.a_lo};
            ACT_NEG:  v = -a;
            ACT_ADD:  v = a + b;
            ACT_SUB:  v = a - b;
            ACT_MUL:  v = a * b;
            ACT_SHL:  v = a << op.shift_amount;
            ACT_SHR:  v = a >> op.shift_amount;
            default:  v = $signed(a) >>> op.shift_amount;
        endcase
        r.res_lo = v[WORD_W-1:0];
        r.res_hi = v[VALUE_W-1:WORD_W];
        return r;
    endfunction

    class alu_scoreboard;
        pending_op_t pending_q[$];
        int unsigned errors;

        function void note_request(req_t op);
            pending_op_t p;
            p.op  = op;
            p.res = alu_result(op);
            pending_q.push_back(p);
        endfunction

        function void check_result(rsp_t got);
            pending_op_t want;
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("unexpected result hi=%h lo=%h", got.res_hi, got.res_lo);
                return;
            end
            want = pending_q.pop_front();
            if (got.res_lo !== want.res.res_lo || got.res_hi !== want.res.res_hi)
            begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("mismatch %s a=%h_%h b=%h_%h sh=%0d: exp %h_%h got %h_%h",
                             want.op.action.name(), want.op.a_hi, want.op.a_lo,
                             want.op.b_hi, want.op.b_lo, want.op.shift_amount,
                             want.res.res_hi, want.res.res_lo, got.res_hi, got.res_lo);
            end
        endfunction
    endclass

    alu_scoreboard results_sb = new();

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // corner words mixed with fully random ones
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(11))
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7fff_ffff_ffff_ffff;
            4:       return 64'd1;
            5:       return {32'd0, $urandom};
            6:       return {32'hffff_ffff, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [SHAMT_W-1:0] pick_shift();
        case ($urandom_range(5))
            0:       return '0;
            1:       return 7'd127;
            2:       return 7'(63 + $urandom_range(2));
            default: return 7'($urandom_range(127));
        endcase
    endfunction

    function automatic req_t random_req();
        req_t r;
        r.action       = action_t'($urandom_range(7));
        r.a_lo         = pick_word();
        r.a_hi         = pick_word();
        r.b_lo         = pick_word();
        r.b_hi         = pick_word();
        r.shift_amount = pick_shift();
        return r;
    endfunction

    function automatic req_t make_op(action_t act, logic [WORD_W-1:0] a_hi,
                                     logic [WORD_W-1:0] a_lo, logic [WORD_W-1:0] b_hi,
                                     logic [WORD_W-1:0] b_lo, logic [SHAMT_W-1:0] sh);
        req_t r;
        r.action       = act;
        r.a_lo         = a_lo;
        r.a_hi         = a_hi;
        r.b_lo         = b_lo;
        r.b_hi         = b_hi;
        r.shift_amount = sh;
        return r;
    endfunction

    // entered and left at a falling edge; valid stays high across back-to-back transfers
    task automatic send_op(input req_t op);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_valid = 1'b0;
            req       = random_req();
            @(negedge clk);
        end
        req       = op;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        results_sb.note_request(op);
        @(negedge clk);
    endtask

    always @(negedge clk)
        rsp_stall = ($urandom_range(99) < rsp_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            results_sb.check_result(rsp);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("tb_int128_alu_unit failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_stall     = 1'b0;
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        quiet_cycles  = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sign extension, unused fields carry junk
        send_op(make_op(ACT_SEXT, '1, 64'h7fff_ffff_ffff_ffff, '1, '1, 7'd127));
        send_op(make_op(ACT_SEXT, '0, 64'h8000_0000_0000_0000, '1, '1, 7'd5));
        // negate: zero, most negative, one
        send_op(make_op(ACT_NEG, '0, '0, '1, '1, 7'd9));
        send_op(make_op(ACT_NEG, 64'h8000_0000_0000_0000, '0, '0, '0, '0));
        send_op(make_op(ACT_NEG, '0, 64'd1, '0, '0, '0));
        // add: carry into the high half, wrap at 2^128, signed overflow
        send_op(make_op(ACT_ADD, '0, '1, '0, 64'd1, '0));
        send_op(make_op(ACT_ADD, '1, '1, '0, 64'd1, 7'd127));
        send_op(make_op(ACT_ADD, 64'h7fff_ffff_ffff_ffff, '1, '0, 64'd1, '0));
        // sub: borrow out of the low half, wrap below zero
        send_op(make_op(ACT_SUB, '0, '0, '0, 64'd1, '0));
        send_op(make_op(ACT_SUB, 64'd1, '0, '0, 64'd1, '0));
        send_op(make_op(ACT_SUB, 64'h8000_0000_0000_0000, '0, '0, 64'd1, '0));
        // mul: all ones, cross terms wrapping out, full low product
        send_op(make_op(ACT_MUL, '1, '1, '1, '1, '0));
        send_op(make_op(ACT_MUL, 64'd1, '0, 64'd1, '0, '0));
        send_op(make_op(ACT_MUL, '0, '1, '0, '1, '0));
        send_op(make_op(ACT_MUL, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                        64'h0f0f_0f0f_f0f0_f0f0, 64'hdead_beef_cafe_f00d, '0));
        // shifts at zero, word boundary and the top
        send_op(make_op(ACT_SHL, 64'h8000_0000_0000_0001, '1, '1, '1, 7'd0));
        send_op(make_op(ACT_SHL, '0, 64'h8000_0000_0000_0001, '0, '0, 7'd1));
        send_op(make_op(ACT_SHL, '1, '1, '0, '0, 7'd64));
        send_op(make_op(ACT_SHL, '1, '1, '0, '0, 7'd127));
        send_op(make_op(ACT_SHR, '1, '1, '1, '1, 7'd0));
        send_op(make_op(ACT_SHR, '1, '1, '0, '0, 7'd63));
        send_op(make_op(ACT_SHR, '1, '1, '0, '0, 7'd127));
        send_op(make_op(ACT_SAR, 64'h8000_0000_0000_0000, '0, '0, '0, 7'd64));
        send_op(make_op(ACT_SAR, 64'h8000_0000_0000_0000, 64'd1, '0, '0, 7'd127));
        send_op(make_op(ACT_SAR, 64'h7fff_ffff_ffff_ffff, '1, '0, '0, 7'd65));

        for (int p = 0; p < PHASES; p++)
        begin
            req_idle_pct  = idle_by_phase[p];
            rsp_stall_pct = stall_by_phase[p];
            repeat (RANDOM_OPS / PHASES)
                send_op(random_req());
        end
        req_valid = 1'b0;

        while (results_sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (results_sb.errors == 0 && results_sb.pending_q.size() == 0)
            $display("tb_int128_alu_unit passed");
        else
            $display("tb_int128_alu_unit failed");
        $finish;
    end

endmodule

/* files.f */
design/i128alu_pkg.sv
design/int128_alu_unit.sv
sim/tb_int128_alu_unit.sv
